/* design/smpc_pkg.sv */
// Shared types and constants for the shadow memory poison checker.
// Used by every module of the block but smpc_ram; depends on nothing.
package smpc_pkg;

   localparam int DEF_GRANULE_BYTES  = 8;
   localparam int DEF_SHADOW_ENTRIES = 4096;

   localparam int ADDR_W   = 48;
   localparam int SIZE_W   = 16;
   localparam int SHADOW_W = 8;
   localparam int STATUS_W = 2;

   localparam logic FUNC_POISON = 1'b0;
   localparam logic FUNC_CHECK  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

   typedef struct packed {
      logic                func;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
      logic [SHADOW_W-1:0] poison_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                poisoned;
      logic [ADDR_W-1:0]   first_bad_addr;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_req;
      logic calc_rel;
      logic calc_end;
      logic decide;
      logic clear_step;
      logic write_step;
      logic read_step;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clear_last;
      logic idx_last;
      logic is_check;
      logic poison_reject;
      logic size_zero;
      logic check_skip;
      logic rsp_busy;
   } sts_type;

endpackage

/* design/smpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/smpc_ctrl.sv */
// Sequencing state machine of the shadow memory poison checker.
// Depends on smpc_pkg; drives the datapath through cmd_type, reads sts_type.
module smpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output smpc_pkg::cmd_type cmd,
   input  smpc_pkg::sts_type sts
);
   import smpc_pkg::*;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_REL    = 4'd2;
   localparam logic [3:0] ST_END    = 4'd3;
   localparam logic [3:0] ST_DECIDE = 4'd4;
   localparam logic [3:0] ST_WRITE  = 4'd5;
   localparam logic [3:0] ST_SCAN   = 4'd6;
   localparam logic [3:0] ST_DRAIN  = 4'd7;
   localparam logic [3:0] ST_FIN    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_REL;
            end
         end
         ST_REL: begin
            cmd.calc_rel = 1'b1;
            state_in     = ST_END;
         end
         ST_END: begin
            cmd.calc_end = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.is_check) begin
               state_in = sts.check_skip ? ST_FIN : ST_SCAN;
            end else if (sts.poison_reject || sts.size_zero) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_step = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_FIN;
            end
         end
         ST_SCAN: begin
            cmd.read_step = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* design/smpc_datapath.sv */
// Datapath of the shadow memory poison checker: window register, request
// registers, range arithmetic, shadow RAM, scan evaluation and output stage.
// Depends on smpc_pkg and smpc_ram.
module smpc_datapath #(
   parameter int GRANULE_BYTES  = smpc_pkg::DEF_GRANULE_BYTES,
   parameter int SHADOW_ENTRIES = smpc_pkg::DEF_SHADOW_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [smpc_pkg::ADDR_W-1:0] csr_data,
   input  smpc_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output smpc_pkg::rsp_type           rsp_payload,
   input  smpc_pkg::cmd_type           cmd,
   output smpc_pkg::sts_type           sts
);
   import smpc_pkg::*;

   localparam int LG  = $clog2(GRANULE_BYTES);
   localparam int IW  = $clog2(SHADOW_ENTRIES);
   localparam int WIN = SHADOW_ENTRIES * GRANULE_BYTES;
   localparam int RW  = $clog2(WIN) + 1;
   localparam int ERW = ((RW > SIZE_W) ? RW : SIZE_W) + 1;

   function automatic logic poisoned_at(input logic [SHADOW_W-1:0] s,
                                        input logic [LG-1:0]       o);
      poisoned_at = (s != '0) && (s[SHADOW_W-1] || (SHADOW_W'(o) >= s));
   endfunction

   logic [ADDR_W-1:0]   window_base_ff;
   logic [ADDR_W-1:0]   ws_al;
   req_type             req_ff;
   logic                rel_ok_ff;
   logic [RW-1:0]       rel_lo_ff;
   logic [ERW-1:0]      end_rel_ff;
   logic [IW-1:0]       first_ff;
   logic [IW-1:0]       last_ff;
   logic [LG-1:0]       hi_off_ff;
   logic [IW-1:0]       idx_ff;
   logic                rd_valid_ff;
   logic [IW-1:0]       rd_idx_ff;
   logic                dirty_ff;
   logic                found_ff;
   logic [IW-1:0]       found_k_ff;
   logic [LG-1:0]       found_off_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [ADDR_W:0]      rel_full;
   logic                 rel_ok_in;
   logic [ERW-1:0]       end_m1;
   logic [ERW-LG-1:0]    end_gran_m1;
   logic [IW-1:0]        last_in;
   logic [LG-1:0]        lo_off;
   logic                 aligned_a;
   logic                 aligned_e;

   logic [SHADOW_W-1:0]  shadow_byte;
   logic                 is_first;
   logic                 is_last;
   logic [LG-1:0]        lo;
   logic [LG-1:0]        hi;
   logic                 s_nz;
   logic                 s_neg;
   logic                 s_small;
   logic [LG-1:0]        cand;
   logic                 found_g;
   logic                 full_g;
   logic                 dirty_g;
   logic [ADDR_W-1:0]    bad_addr;

   assign ws_al = {window_base_ff[ADDR_W-1:LG], {LG{1'b0}}};

   // Range arithmetic relative to the window start.
   assign rel_full  = {1'b0, req_ff.addr} - {1'b0, ws_al};
   assign rel_ok_in = !rel_full[ADDR_W] && (rel_full[ADDR_W-1:0] < ADDR_W'(WIN));
   assign end_m1      = end_rel_ff - ERW'(1);
   assign end_gran_m1 = end_rel_ff[ERW-1:LG] - (ERW-LG)'(1);
   assign last_in     = (req_ff.func == FUNC_CHECK) ? end_m1[LG +: IW] : end_gran_m1[IW-1:0];
   assign lo_off      = req_ff.addr[LG-1:0];
   assign aligned_a   = (lo_off == '0);
   assign aligned_e   = (end_rel_ff[LG-1:0] == '0);

   // Evaluate one granule as its shadow byte returns from the RAM.
   assign is_first = (rd_idx_ff == first_ff);
   assign is_last  = (rd_idx_ff == last_ff);
   assign lo       = is_first ? lo_off : '0;
   assign hi       = is_last ? hi_off_ff : '1;
   assign s_nz     = (shadow_byte != '0);
   assign s_neg    = shadow_byte[SHADOW_W-1];
   assign s_small  = (shadow_byte < SHADOW_W'(GRANULE_BYTES));

   always_comb begin
      if (s_neg) begin
         cand = lo;
      end else if (lo > shadow_byte[LG-1:0]) begin
         cand = lo;
      end else begin
         cand = shadow_byte[LG-1:0];
      end
   end

   assign found_g = s_nz && (s_neg || s_small) && (cand <= hi);
   assign full_g  = (!is_first || (lo_off == '0)) && (!is_last || (hi_off_ff == '1));
   assign dirty_g = (full_g && s_nz)
                 || (is_first && poisoned_at(shadow_byte, lo_off))
                 || (is_last && poisoned_at(shadow_byte, hi_off_ff));

   assign bad_addr = ws_al + ADDR_W'({found_k_ff, found_off_ff});

   always_comb begin
      rsp_in = '0;
      if (req_ff.func == FUNC_POISON) begin
         rsp_in.status = sts.poison_reject ? STATUS_REJECT : STATUS_OK;
      end else if (!sts.check_skip && dirty_ff) begin
         if (found_ff) begin
            rsp_in.status         = STATUS_OK;
            rsp_in.poisoned       = 1'b1;
            rsp_in.first_bad_addr = bad_addr;
         end else begin
            rsp_in.status = STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff <= '0;
         idx_ff         <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         dirty_ff       <= 1'b0;
         found_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            window_base_ff <= csr_data;
         end
         rd_valid_ff <= cmd.read_step;
         if (cmd.decide) begin
            idx_ff   <= rel_lo_ff[LG +: IW];
            dirty_ff <= 1'b0;
            found_ff <= 1'b0;
         end else if (cmd.clear_step || cmd.write_step || cmd.read_step) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (rd_valid_ff) begin
            dirty_ff <= dirty_ff | dirty_g;
            if (found_g && !found_ff) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.calc_rel) begin
         rel_ok_ff <= rel_ok_in;
         rel_lo_ff <= rel_full[RW-1:0];
      end
      if (cmd.calc_end) begin
         end_rel_ff <= ERW'(rel_lo_ff) + ERW'(req_ff.size);
      end
      if (cmd.decide) begin
         first_ff  <= rel_lo_ff[LG +: IW];
         last_ff   <= last_in;
         hi_off_ff <= end_m1[LG-1:0];
      end
      rd_idx_ff <= idx_ff;
      if (rd_valid_ff && found_g && !found_ff) begin
         found_k_ff   <= rd_idx_ff;
         found_off_ff <= cand;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   smpc_ram #(
      .WIDTH (SHADOW_W),
      .DEPTH (SHADOW_ENTRIES)
   ) u_shadow_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_step || cmd.write_step),
      .wr_addr (idx_ff),
      .wr_data (cmd.clear_step ? '0 : req_ff.poison_value),
      .rd_en   (cmd.read_step),
      .rd_addr (idx_ff),
      .rd_data (shadow_byte)
   );

   assign sts.clear_last    = (idx_ff == IW'(SHADOW_ENTRIES - 1));
   assign sts.idx_last      = (idx_ff == last_ff);
   assign sts.is_check      = (req_ff.func == FUNC_CHECK);
   assign sts.size_zero     = (req_ff.size == '0);
   assign sts.poison_reject = !aligned_a || !aligned_e || !rel_ok_ff
                           || ((req_ff.size != '0) && (end_rel_ff > ERW'(WIN)));
   assign sts.check_skip    = (req_ff.size == '0) || !rel_ok_ff || (end_rel_ff >= ERW'(WIN));
   assign sts.rsp_busy      = rsp_valid_ff && rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/shadow_memory_poison_checker.sv */
// Shadow memory poison checker: one shadow byte per granule of a memory window
// starting at csr window_base. A poison command (func 0) fills the shadow bytes
// of a granule-aligned region with poison_value (zero unpoisons); a misaligned
// or out-of-window request returns status 1 and writes nothing. A check command
// (func 1) scans a byte region and returns the first poisoned byte, status 2 if
// the quick test flagged the region but no byte is poisoned, or a clean result
// for an empty or out-of-window region. After the request transfer come setup
// states for window offset, region end and decide; a command that is not
// rejected, empty or out of window then walks its granules (one RAM port
// access per granule), a check that scans passes a drain state, and a final
// state loads the output register. Commands run one at a time. A finished
// result waits in the output register while the next request is accepted; if
// that one finishes while the first result is still stalled, it holds in the
// final state with req_stall high until the first transfers. After reset the
// block sweeps the shadow RAM to zero with req_stall held high.
// Depends on smpc_pkg, smpc_ctrl, smpc_datapath and smpc_ram.
module shadow_memory_poison_checker #(
   parameter int GRANULE_BYTES  = smpc_pkg::DEF_GRANULE_BYTES,
   parameter int SHADOW_ENTRIES = smpc_pkg::DEF_SHADOW_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration write: window base address.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [smpc_pkg::ADDR_W-1:0] csr_data,
   // Request channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  smpc_pkg::req_type           req_payload,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output smpc_pkg::rsp_type           rsp_payload
);
   import smpc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Users keep configuration writes to idle (not enforced); none are stalled.
   assign csr_ready = 1'b1;

   // Sequence each command: setup, walk the granules, then hand off the result.
   smpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Hold the window, the request, the shadow RAM and the output register.
   smpc_datapath #(
      .GRANULE_BYTES  (GRANULE_BYTES),
      .SHADOW_ENTRIES (SHADOW_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

/* design/smpc_checker.sv */
// Port-level assertions for the shadow memory poison checker, bound to the top.
// Depends on smpc_pkg.
module smpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input smpc_pkg::rsp_type rsp_payload
);
   import smpc_pkg::*;

   // Reset starts the clearing sweep, so no request is taken right after it.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during shadow clear");

   // One command at a time: a transfer makes the block busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !$rose(rsp_valid)))
      else $error("block not busy after request transfer");

   // A held result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result changed while stalled");

   // A hit always carries status ok.
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.poisoned) |-> (rsp_payload.status == STATUS_OK))
      else $error("poisoned result with error status");

   // Without a hit the address is zero.
   a_miss_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.poisoned) |-> (rsp_payload.first_bad_addr == '0))
      else $error("address reported without a hit");

endmodule

bind shadow_memory_poison_checker smpc_checker u_smpc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

/* verif/shadow_memory_poison_checker_tb.sv */
// Testbench for shadow_memory_poison_checker: directed and random poison and check
// commands, scored against a shadow-memory predictor kept inside this file.
// Depends on smpc_pkg and the shadow_memory_poison_checker RTL.
module shadow_memory_poison_checker_tb;
   import smpc_pkg::*;

   localparam int          GRAN           = DEF_GRANULE_BYTES;
   localparam int          ENTRIES        = DEF_SHADOW_ENTRIES;
   localparam logic [63:0] GRAN64         = 64'(DEF_GRANULE_BYTES);
   localparam logic [63:0] WIN_BYTES      = 64'(DEF_GRANULE_BYTES * DEF_SHADOW_ENTRIES);
   localparam logic [63:0] ADDR_MASK      = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] TOP_BASE       = 64'hFFFF_FFFF_FFF8;
   localparam int          HOLD_CYCLES    = 3000;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          PHASES         = 10;
   localparam int          PHASE_ITEMS    = 95;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_valid;
   logic    csr_ready;
   logic [ADDR_W-1:0] csr_data;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Predictor state: our own copy of the shadow bytes and the window start.
   logic [SHADOW_W-1:0] shadow_copy [0:ENTRIES-1];
   logic [63:0]         window_lo;
   logic [63:0]         recent_poison;
   rsp_type             expected_verdicts [$];

   int error_count;
   int idle_pct;
   int idle_cycles;
   bit hold_rsp;

   always #5 clock = ~clock;

   shadow_memory_poison_checker DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Window arithmetic runs in 64 bits, so a window near the top of the
   // 48-bit space reaches past it and region ends may lie beyond 2^48.
   function automatic bit in_window(logic [63:0] a);
      return (a >= window_lo) && ((a - window_lo) < WIN_BYTES);
   endfunction

   function automatic int shadow_idx(logic [63:0] a);
      return int'((a - window_lo) / GRAN64);
   endfunction

   // A byte is bad when its shadow is nonzero and its granule offset is at
   // least the shadow read as a signed byte (negative shadow: whole granule).
   function automatic bit byte_is_bad(logic [63:0] a);
      logic [SHADOW_W-1:0] s;
      int                  off;
      if (!in_window(a))
         return 1'b0;
      s   = shadow_copy[shadow_idx(a)];
      off = int'(a % GRAN64);
      return (s != '0) && (off >= int'($signed(s)));
   endfunction

   // Apply one command to the predictor state and return its verdict.
   function automatic rsp_type shadow_predict(req_type r);
      rsp_type             res;
      logic [63:0]         a, fin, abeg, aend, g, gb, lo, hi, cand;
      logic [SHADOW_W-1:0] s;
      int                  sv;
      bit                  dirty;
      res = '0;
      a   = 64'(r.addr);
      fin = a + 64'(r.size);

      if (r.func == FUNC_POISON) begin
         // Reject misaligned bounds and a start outside the window.
         if ((a % GRAN64) != 0 || (fin % GRAN64) != 0 || !in_window(a)) begin
            res.status = STATUS_REJECT;
         end else if (r.size != '0) begin
            if (!in_window(fin - GRAN64)) begin
               res.status = STATUS_REJECT;
            end else begin
               for (int i = shadow_idx(a); i <= shadow_idx(fin - GRAN64); i++)
                  shadow_copy[i] = r.poison_value;
            end
         end
         return res;
      end

      // Empty region or one that leaves the window reads as clean.
      if (r.size == '0 || !in_window(a) || !in_window(fin))
         return res;

      // Quick test: both end bytes, then every whole granule in between.
      dirty = byte_is_bad(a) || byte_is_bad(fin - 1);
      abeg  = (a + GRAN64 - 1) / GRAN64 * GRAN64;
      aend  = fin / GRAN64 * GRAN64;
      for (g = abeg; !dirty && g < aend; g += GRAN64)
         if (shadow_copy[shadow_idx(g)] != '0)
            dirty = 1'b1;
      if (!dirty)
         return res;

      // Full scan, one granule at a time, for the first bad byte.
      for (int i = shadow_idx(a); i <= shadow_idx(fin - 1); i++) begin
         gb = window_lo + 64'(i) * GRAN64;
         lo = (a > gb) ? a : gb;
         hi = (fin < gb + GRAN64) ? fin : gb + GRAN64;
         s  = shadow_copy[i];
         sv = int'($signed(s));
         if (s != '0 && sv < GRAN) begin
            cand = (sv <= 0) ? gb : gb + 64'(sv);
            if (cand < lo)
               cand = lo;
            if (cand < hi) begin
               res.poisoned       = 1'b1;
               res.first_bad_addr = cand[ADDR_W-1:0];
               return res;
            end
         end
      end
      // Flagged by the quick test, but nothing bad on the byte scan.
      res.status = STATUS_EMPTY;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Handshake helpers
   // ------------------------------------------------------------------

   // Mostly no gap; when idling is on, mostly short gaps and a few long ones.
   function automatic int pick_gap();
      if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(20, 80);
      return $urandom_range(1, 4);
   endfunction

   // Offer one command and hold it until the transfer; valid stays high on
   // return so back-to-back commands need no dead cycle.
   task automatic send_cmd(logic func, logic [63:0] addr, int unsigned size,
                           int unsigned value);
      req_type r;
      int      gap;
      r.func         = func;
      r.addr         = addr[ADDR_W-1:0];
      r.size         = size[SIZE_W-1:0];
      r.poison_value = value[SHADOW_W-1:0];
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      expected_verdicts.push_back(shadow_predict(r));
   endtask

   // Drop valid, wait for every verdict, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the window base only once the block has gone quiet.
   task automatic write_window(logic [63:0] base);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= base[ADDR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_lo = (base & ADDR_MASK) / GRAN64 * GRAN64;
   endtask

   // One random command: well-formed poisons and checks inside the window
   // for the most part, with some noise and broken requests mixed in.
   task automatic random_cmd();
      int          kind, g, n, room, r;
      logic [63:0] a;
      int unsigned len, val;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         g    = $urandom_range(0, ENTRIES - 1);
         room = ENTRIES - g;
         r    = $urandom_range(0, 99);
         if (r < 70)
            n = $urandom_range(1, (room < 8) ? room : 8);
         else if (r < 97)
            n = $urandom_range(1, (room < 64) ? room : 64);
         else
            n = $urandom_range(1, room);
         r = $urandom_range(0, 99);
         if (r < 25)
            val = 0;
         else if (r < 55)
            val = $urandom_range(1, GRAN - 1);
         else if (r < 70)
            val = $urandom_range(GRAN, 127);
         else if (r < 90)
            val = $urandom_range(128, 255);
         else
            val = $urandom_range(0, 255);
         a = window_lo + 64'(g) * GRAN64;
         recent_poison = a;
         send_cmd(FUNC_POISON, a, n * GRAN, val);
      end else if (kind < 85) begin
         // Half the checks land near the latest poison to hit partial granules.
         if ($urandom_range(0, 1) == 0)
            a = recent_poison + 64'($urandom_range(0, 96)) - 64'd32;
         else
            a = window_lo + 64'($urandom_range(0, int'(WIN_BYTES) - 1));
         r = $urandom_range(0, 99);
         if (r < 75)
            len = $urandom_range(1, 128);
         else if (r < 97)
            len = $urandom_range(1, 1024);
         else
            len = $urandom_range(1, int'(WIN_BYTES));
         send_cmd(FUNC_CHECK, a, len, $urandom_range(0, 255));
      end else if (kind < 92) begin
         // Noise near the window edges: misaligned bounds and crossings.
         a = window_lo + 64'($urandom_range(0, int'(WIN_BYTES) + 64)) - 64'd32;
         send_cmd(1'($urandom_range(0, 1)), a, $urandom_range(0, 40),
                  $urandom_range(0, 255));
      end else begin
         // Fully random fields, so every bit of every field toggles.
         a = 64'({$urandom, $urandom}) & ADDR_MASK;
         send_cmd(1'($urandom_range(0, 1)), a, $urandom_range(0, 65535),
                  $urandom_range(0, 255));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Poison, partial granules, unpoison and the no-hit scan, window at zero.
   task automatic test_poison_basics();
      write_window(64'h0);
      send_cmd(FUNC_CHECK,  64'd0,    0,     0);      // empty region
      send_cmd(FUNC_CHECK,  64'd0,    32,    0);      // clean memory
      send_cmd(FUNC_POISON, 64'd64,   64,    8'hFF);  // whole granules bad
      send_cmd(FUNC_CHECK,  64'd60,   16,    0);
      send_cmd(FUNC_POISON, 64'd256,  8,     3);      // partial granule
      send_cmd(FUNC_CHECK,  64'd256,  8,     0);
      send_cmd(FUNC_CHECK,  64'd256,  3,     0);      // only the good bytes
      send_cmd(FUNC_POISON, 64'd512,  8,     GRAN);   // quick test hit, no bad byte
      send_cmd(FUNC_CHECK,  64'd512,  8,     0);
      send_cmd(FUNC_POISON, 64'd1024, 16,    8'h80);  // most negative shadow
      send_cmd(FUNC_CHECK,  64'd1020, 12,    0);
      send_cmd(FUNC_POISON, 64'd64,   64,    0);      // unpoison
      send_cmd(FUNC_CHECK,  64'd60,   16,    0);
   endtask

   // Every way a poison can be refused, plus the window-edge checks.
   task automatic test_poison_rejects();
      send_cmd(FUNC_POISON, 64'd65,    8,     1);     // misaligned start
      send_cmd(FUNC_POISON, 64'd64,    12,    1);     // misaligned end
      send_cmd(FUNC_POISON, WIN_BYTES, 8,     1);     // start past the window
      send_cmd(FUNC_POISON, WIN_BYTES - 8, 16, 1);    // last granule outside
      send_cmd(FUNC_POISON, WIN_BYTES - 8, 8,  7);    // last entry, accepted
      send_cmd(FUNC_POISON, 64'd8,     0,     5);     // empty, aligned
      send_cmd(FUNC_POISON, 64'd9,     0,     5);     // empty, misaligned
      send_cmd(FUNC_POISON, 64'd40000, 0,     5);     // empty, outside
      send_cmd(FUNC_CHECK,  WIN_BYTES - 8, 8,  0);    // end leaves the window
      send_cmd(FUNC_CHECK,  ADDR_MASK, 16'hFFFF, 8'hFF);
      send_cmd(FUNC_POISON, ADDR_MASK, 16'hFFFF, 8'hFF);
      send_cmd(FUNC_POISON, 64'd0,     int'(WIN_BYTES), 0);  // clear the window
   endtask

   // Move the window: unaligned base, the top of the address space, and back.
   task automatic test_window_base();
      write_window(64'h1234_5678_9ABF);
      send_cmd(FUNC_POISON, window_lo + 8, 8, 2);
      send_cmd(FUNC_CHECK,  window_lo + 8, 8, 0);
      send_cmd(FUNC_CHECK,  64'd0,         8, 0);
      write_window(TOP_BASE);
      send_cmd(FUNC_POISON, TOP_BASE, 16, 8'hFF);     // runs past 2^48
      send_cmd(FUNC_CHECK,  TOP_BASE, 16, 0);
      write_window(ADDR_MASK);                        // low bits ignored
      send_cmd(FUNC_CHECK,  TOP_BASE + 4, 4, 0);
      send_cmd(FUNC_POISON, TOP_BASE, 16, 0);
      write_window(64'h0);
   endtask

   // Hold the result side off for a long stretch while commands keep coming,
   // so the output register fills and the block stalls its input.
   task automatic test_backpressure();
      idle_pct = 0;
      hold_rsp = 1'b1;
      repeat (30) random_cmd();
      wait_idle();
   endtask

   // Random phases with varying idling levels; each phase after the first moves the window base.
   task automatic test_random_traffic();
      int r;
      for (int p = 0; p < PHASES; p++) begin
         idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 50);
         if (p != 0) begin
            r = $urandom_range(0, 9);
            if (r == 0)
               write_window(64'h0);
            else if (r == 1)
               write_window(TOP_BASE);
            else
               write_window(64'({$urandom, $urandom}) & ADDR_MASK);
            recent_poison = window_lo;
         end
         repeat (PHASE_ITEMS) random_cmd();
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls, plus the long hold on request
   // ------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Score every result transfer against the oldest expected verdict.
   always @(posedge clock) begin : verdict_check
      rsp_type want;
      if (rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result transfer: status %0d poisoned %0d addr %h",
                   rsp_payload.status, rsp_payload.poisoned, rsp_payload.first_bad_addr);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.poisoned !== want.poisoned) begin
               $error("poisoned: expected %0d, got %0d",
                      want.poisoned, rsp_payload.poisoned);
               error_count++;
            end
            if (rsp_payload.first_bad_addr !== want.first_bad_addr) begin
               $error("first_bad_addr: expected %h, got %h",
                      want.first_bad_addr, rsp_payload.first_bad_addr);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens on any channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("shadow_memory_poison_checker_tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      req_valid   <= 1'b0;
      req_payload <= '0;
      hold_rsp      = 1'b0;
      idle_pct      = 30;
      window_lo     = '0;
      recent_poison = '0;
      for (int i = 0; i < ENTRIES; i++)
         shadow_copy[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_poison_basics();
      test_poison_rejects();
      test_window_base();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      if (error_count == 0)
         $display("shadow_memory_poison_checker_tb: done, clean");
      else
         $display("shadow_memory_poison_checker_tb: done, errors");
      $finish;
   end

endmodule

/* shadow_memory_poison_checker.f */
design/smpc_pkg.sv
design/smpc_ram.sv
design/smpc_ctrl.sv
design/smpc_datapath.sv
design/shadow_memory_poison_checker.sv
design/smpc_checker.sv
verif/shadow_memory_poison_checker_tb.sv
